[hw/rtl/bsa_pkg.sv]
// Bitmap slot allocator: shared constants, register and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package bsa_pkg;

   // slab geometry
   localparam int MAX_SLOTS  = 512;
   localparam int WORD_BITS  = 64;
   localparam int ALIGN_BITS = 3;
   localparam int SLAB_BYTES = 4096;

   localparam int NUM_WORDS  = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int ALIGN_STEP = 1 << ALIGN_BITS;

   // field widths
   localparam int OBJ_W    = 13;
   localparam int OFF_W    = 12;
   localparam int CNT_W    = 10;
   localparam int SLOT_W   = 9;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 4;

   // aligned size and divider widths
   localparam int ASZ_W    = OBJ_W + 1;
   localparam int DIVS_W   = ASZ_W - ALIGN_BITS;
   localparam int SLAB_W   = $clog2(SLAB_BYTES + 1);
   localparam int DIVD_W   = SLAB_W - ALIGN_BITS;
   localparam int DCNT_W   = $clog2(DIVD_W + 1);
   localparam int PROD_W   = SLOT_W + ASZ_W;

   // register reset values
   localparam int RST_OBJ_SIZE  = 8;
   localparam int RST_START_OFF = 64;
   localparam int RST_SLOT_CNT  = 0;

   typedef enum logic [1:0] {
      REG_OBJECT_SIZE  = 2'd0,
      REG_START_OFFSET = 2'd1,
      REG_SLOT_COUNT   = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIT,
      S_SCAN,
      S_MUL,
      S_SLOT,
      S_FREE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [OBJ_W-1:0] obj_size;
      logic [OFF_W-1:0] start_off;
      logic [CNT_W-1:0] slot_cnt;
   } cfg_type;

   typedef struct packed {
      logic       load_req;
      logic       div_start;
      logic       div_sel_slot;
      logic       take_fit;
      logic       take_slot;
      logic       scan_step;
      logic       alloc_apply;
      logic       free_apply;
      logic       set_status;
      status_type status;
      logic       respond;
   } dp_cmd_type;

   typedef struct packed {
      logic op_free;
      logic div_done;
      logic off_low;
      logic slot_bad;
      logic scan_found;
      logic scan_last;
   } dp_stat_type;

endpackage

[hw/rtl/bsa_div.sv]
// Bitmap slot allocator: restoring divider, one quotient bit per cycle.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bsa_pkg::DIVD_W-1:0] dividend,
   input  logic [bsa_pkg::DIVS_W-1:0] divisor,
   output logic                       done,
   output logic [bsa_pkg::DIVD_W-1:0] quotient
);

   logic [bsa_pkg::DCNT_W-1:0] count_ff, count_in;
   logic                       done_ff, done_in;
   logic [bsa_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [bsa_pkg::DIVD_W-1:0] dq_ff, dq_in;
   logic [bsa_pkg::DIVS_W-1:0] dvs_ff, dvs_in;
   logic [bsa_pkg::DIVS_W-1:0] shifted;

   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      dvs_in   = dvs_ff;
      shifted  = {rem_ff[bsa_pkg::DIVS_W-2:0], dq_ff[bsa_pkg::DIVD_W-1]};
      if (start) begin
         count_in = bsa_pkg::DCNT_W'(bsa_pkg::DIVD_W);
         done_in  = 1'b0;
         rem_in   = '0;
         dq_in    = dividend;
         dvs_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (shifted >= dvs_ff) begin
            rem_in = shifted - dvs_ff;
            dq_in  = {dq_ff[bsa_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            dq_in  = {dq_ff[bsa_pkg::DIVD_W-2:0], 1'b0};
         end
         if (count_ff == bsa_pkg::DCNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

[hw/rtl/bsa_dp.sv]
// Bitmap slot allocator datapath: bitmap, used counter, slot scan, offset
// arithmetic and the result register. Depends on bsa_pkg and bsa_div.
`timescale 1ns / 1ps

module bsa_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  bsa_pkg::cfg_type            cfg,
   input  bsa_pkg::dp_cmd_type         cmd,
   output bsa_pkg::dp_stat_type        stat,
   input  logic                        req_opcode,
   input  logic [bsa_pkg::OFF_W-1:0]   req_free_offset,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [bsa_pkg::OFF_W-1:0]   rsp_alloc_offset,
   output logic [bsa_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic [bsa_pkg::CNT_W-1:0]   rsp_used_count,
   output logic                        rsp_is_full
);

   logic [bsa_pkg::WORD_BITS-1:0]  bitmap_ff [bsa_pkg::NUM_WORDS];
   logic [bsa_pkg::CNT_W-1:0]      used_ff;
   logic                           op_ff;
   logic [bsa_pkg::OFF_W-1:0]      foff_ff;
   logic [bsa_pkg::CNT_W-1:0]      n_ff;
   logic [bsa_pkg::WORD_IDX_W-1:0] word_ff;
   logic [bsa_pkg::SLOT_W-1:0]     slot_ff;
   logic [bsa_pkg::OFF_W-1:0]      prod_ff;
   bsa_pkg::status_type            status_ff;

   logic                           rsp_valid_ff;
   logic [1:0]                     rsp_status_ff;
   logic [bsa_pkg::OFF_W-1:0]      rsp_alloc_offset_ff;
   logic [bsa_pkg::SLOT_W-1:0]     rsp_slot_index_ff;
   logic [bsa_pkg::CNT_W-1:0]      rsp_used_count_ff;
   logic                           rsp_is_full_ff;

   // aligned object size
   logic [bsa_pkg::OBJ_W-1:0]      size_nz;
   logic [bsa_pkg::ASZ_W-1:0]      size_up;
   logic [bsa_pkg::DIVS_W-1:0]     size_units;
   logic [bsa_pkg::ASZ_W-1:0]      size_aligned;

   always_comb begin
      size_nz      = (cfg.obj_size == '0) ? bsa_pkg::OBJ_W'(1) : cfg.obj_size;
      size_up      = bsa_pkg::ASZ_W'(size_nz) + bsa_pkg::ASZ_W'(bsa_pkg::ALIGN_STEP - 1);
      size_units   = size_up[bsa_pkg::ASZ_W-1:bsa_pkg::ALIGN_BITS];
      size_aligned = bsa_pkg::ASZ_W'(size_units) << bsa_pkg::ALIGN_BITS;
   end

   // divider operands
   logic [bsa_pkg::SLAB_W-1:0]     slab_rem;
   logic [bsa_pkg::OFF_W-1:0]      free_rel;
   logic [bsa_pkg::DIVD_W-1:0]     div_dividend;
   logic [bsa_pkg::DIVD_W-1:0]     div_quo;
   logic                           div_done;

   always_comb begin
      slab_rem = bsa_pkg::SLAB_W'(bsa_pkg::SLAB_BYTES) - bsa_pkg::SLAB_W'(cfg.start_off);
      free_rel = foff_ff - cfg.start_off;
      if (cmd.div_sel_slot) begin
         div_dividend = bsa_pkg::DIVD_W'(free_rel[bsa_pkg::OFF_W-1:bsa_pkg::ALIGN_BITS]);
      end else begin
         div_dividend = slab_rem[bsa_pkg::SLAB_W-1:bsa_pkg::ALIGN_BITS];
      end
   end

   bsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (size_units),
      .done     (div_done),
      .quotient (div_quo)
   );

   // usable slot count
   logic [bsa_pkg::CNT_W-1:0]      n_in;
   logic [bsa_pkg::CNT_W-1:0]      fit_cnt;

   always_comb begin
      fit_cnt = bsa_pkg::CNT_W'(div_quo);
      n_in    = cfg.slot_cnt;
      if (n_in > bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS)) begin
         n_in = bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS);
      end
      if (n_in > fit_cnt) begin
         n_in = fit_cnt;
      end
   end

   // one bitmap word per scan step
   logic [bsa_pkg::WORD_BITS-1:0]  scan_word;
   logic [bsa_pkg::SLOT_W-1:0]     scan_base;
   logic [bsa_pkg::CNT_W-1:0]      scan_remain;
   logic [bsa_pkg::WORD_BITS-1:0]  scan_avail;
   logic [bsa_pkg::BIT_IDX_W-1:0]  scan_first;
   logic                           scan_found;
   logic                           scan_last;

   always_comb begin
      scan_word  = bitmap_ff[word_ff];
      scan_base  = {word_ff, {bsa_pkg::BIT_IDX_W{1'b0}}};
      scan_remain = (n_ff > bsa_pkg::CNT_W'(scan_base)) ?
                    n_ff - bsa_pkg::CNT_W'(scan_base) : '0;
      for (int b = 0; b < bsa_pkg::WORD_BITS; b++) begin
         scan_avail[b] = ~scan_word[b] && (bsa_pkg::CNT_W'(b) < scan_remain);
      end
      scan_first = '0;
      for (int b = bsa_pkg::WORD_BITS - 1; b >= 0; b--) begin
         if (scan_avail[b]) begin
            scan_first = bsa_pkg::BIT_IDX_W'(b);
         end
      end
      scan_found = |scan_avail;
      scan_last  = ((bsa_pkg::CNT_W + 1)'(scan_base) + (bsa_pkg::CNT_W + 1)'(bsa_pkg::WORD_BITS)
                    >= (bsa_pkg::CNT_W + 1)'(n_ff))
                   || (word_ff == bsa_pkg::WORD_IDX_W'(bsa_pkg::NUM_WORDS - 1));
   end

   logic [bsa_pkg::PROD_W-1:0]     prod_full;
   logic [bsa_pkg::WORD_IDX_W-1:0] slot_word;
   logic [bsa_pkg::BIT_IDX_W-1:0]  slot_bit;

   always_comb begin
      prod_full = slot_ff * size_aligned;
      slot_word = slot_ff[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_IDX_W];
      slot_bit  = slot_ff[bsa_pkg::BIT_IDX_W-1:0];
   end

   always_comb begin
      stat.op_free    = op_ff;
      stat.div_done   = div_done;
      stat.off_low    = foff_ff < cfg.start_off;
      stat.slot_bad   = div_quo >= bsa_pkg::DIVD_W'(bsa_pkg::MAX_SLOTS);
      stat.scan_found = scan_found;
      stat.scan_last  = scan_last;
   end

   // bitmap and used count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < bsa_pkg::NUM_WORDS; w++) begin
            bitmap_ff[w] <= '0;
         end
         used_ff <= '0;
      end else if (cmd.alloc_apply) begin
         bitmap_ff[slot_word][slot_bit] <= 1'b1;
         used_ff <= used_ff + 1'b1;
      end else if (cmd.free_apply && bitmap_ff[slot_word][slot_bit]) begin
         bitmap_ff[slot_word][slot_bit] <= 1'b0;
         if (used_ff != '0) begin
            used_ff <= used_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
      if (cmd.load_req) begin
         op_ff     <= req_opcode;
         foff_ff   <= req_free_offset;
         word_ff   <= '0;
         status_ff <= bsa_pkg::ST_DONE;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.take_fit) begin
         n_ff <= n_in;
      end
      if (cmd.take_slot) begin
         slot_ff <= bsa_pkg::SLOT_W'(div_quo);
      end
      if (cmd.scan_step) begin
         if (scan_found) begin
            slot_ff <= {word_ff, scan_first};
         end else if (!scan_last) begin
            word_ff <= word_ff + 1'b1;
         end
      end
      if (cmd.alloc_apply) begin
         prod_ff <= prod_full[bsa_pkg::OFF_W-1:0];
      end
      if (cmd.respond) begin
         rsp_status_ff     <= status_ff;
         rsp_used_count_ff <= used_ff;
         rsp_is_full_ff    <= used_ff >= n_ff;
         if (status_ff == bsa_pkg::ST_DONE) begin
            rsp_slot_index_ff   <= slot_ff;
            rsp_alloc_offset_ff <= op_ff ? '0 : cfg.start_off + prod_ff;
         end else begin
            rsp_slot_index_ff   <= '0;
            rsp_alloc_offset_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_offset = rsp_alloc_offset_ff;
   assign rsp_slot_index   = rsp_slot_index_ff;
   assign rsp_used_count   = rsp_used_count_ff;
   assign rsp_is_full      = rsp_is_full_ff;

endmodule

[hw/rtl/bsa_ctrl.sv]
// Bitmap slot allocator controller: sequences the divider, scan, update
// and result steps of one request. Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bsa_pkg::dp_stat_type  stat,
   output bsa_pkg::dp_cmd_type   cmd
);

   bsa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.status = bsa_pkg::ST_DONE;
      unique case (state_ff)
         bsa_pkg::S_IDLE: begin
            if (start) begin
               cmd.load_req  = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = bsa_pkg::S_FIT;
            end
         end
         bsa_pkg::S_FIT: begin
            if (stat.div_done) begin
               cmd.take_fit = 1'b1;
               if (!stat.op_free) begin
                  state_in = bsa_pkg::S_SCAN;
               end else if (stat.off_low) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = bsa_pkg::ST_BAD;
                  state_in       = bsa_pkg::S_RESP;
               end else begin
                  cmd.div_start    = 1'b1;
                  cmd.div_sel_slot = 1'b1;
                  state_in         = bsa_pkg::S_SLOT;
               end
            end
         end
         bsa_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_found) begin
               state_in = bsa_pkg::S_MUL;
            end else if (stat.scan_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = bsa_pkg::ST_FULL;
               state_in       = bsa_pkg::S_RESP;
            end
         end
         bsa_pkg::S_MUL: begin
            cmd.alloc_apply = 1'b1;
            state_in        = bsa_pkg::S_RESP;
         end
         bsa_pkg::S_SLOT: begin
            cmd.div_sel_slot = 1'b1;
            if (stat.div_done) begin
               if (stat.slot_bad) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = bsa_pkg::ST_BAD;
                  state_in       = bsa_pkg::S_RESP;
               end else begin
                  cmd.take_slot = 1'b1;
                  state_in      = bsa_pkg::S_FREE;
               end
            end
         end
         bsa_pkg::S_FREE: begin
            cmd.free_apply = 1'b1;
            state_in       = bsa_pkg::S_RESP;
         end
         bsa_pkg::S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = bsa_pkg::S_IDLE;
         end
         default: begin
            state_in = bsa_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != bsa_pkg::S_IDLE);

endmodule

[hw/rtl/bsa_csr.sv]
// Bitmap slot allocator configuration registers behind an APB-style port.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bsa_pkg::ADDR_W-1:0]  paddr,
   input  logic [bsa_pkg::DATA_W-1:0]  pwdata,
   output logic [bsa_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output bsa_pkg::cfg_type            cfg
);

   logic [bsa_pkg::OBJ_W-1:0] obj_size_ff;
   logic [bsa_pkg::OFF_W-1:0] start_off_ff;
   logic [bsa_pkg::CNT_W-1:0] slot_cnt_ff;
   bsa_pkg::reg_index_type    reg_sel;
   logic                      wr_en;

   assign reg_sel = bsa_pkg::reg_index_type'(paddr[bsa_pkg::ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_size_ff  <= bsa_pkg::OBJ_W'(bsa_pkg::RST_OBJ_SIZE);
         start_off_ff <= bsa_pkg::OFF_W'(bsa_pkg::RST_START_OFF);
         slot_cnt_ff  <= bsa_pkg::CNT_W'(bsa_pkg::RST_SLOT_CNT);
      end else if (wr_en) begin
         unique case (reg_sel)
            bsa_pkg::REG_OBJECT_SIZE:  obj_size_ff  <= pwdata[bsa_pkg::OBJ_W-1:0];
            bsa_pkg::REG_START_OFFSET: start_off_ff <= pwdata[bsa_pkg::OFF_W-1:0];
            bsa_pkg::REG_SLOT_COUNT:   slot_cnt_ff  <= pwdata[bsa_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         bsa_pkg::REG_OBJECT_SIZE:  prdata = bsa_pkg::DATA_W'(obj_size_ff);
         bsa_pkg::REG_START_OFFSET: prdata = bsa_pkg::DATA_W'(start_off_ff);
         bsa_pkg::REG_SLOT_COUNT:   prdata = bsa_pkg::DATA_W'(slot_cnt_ff);
         default:                   prdata = '0;
      endcase
   end

   assign cfg.obj_size  = obj_size_ff;
   assign cfg.start_off = start_off_ff;
   assign cfg.slot_cnt  = slot_cnt_ff;

endmodule

[hw/rtl/bitmap_slot_allocator.sv]
// Bitmap slot allocator top level: configuration registers, controller, datapath.
// Depends on bsa_pkg, bsa_csr, bsa_ctrl and bsa_dp.
`timescale 1ns / 1ps

// One request at a time: a request is taken when start is high and busy low,
// and its result appears on the rsp_ ports for a single cycle with rsp_valid;
// the receiver must take it then. Both usable-slot and slot-index figures come
// from a shared restoring divider at one quotient bit a cycle. An allocate
// scans the 64-bit bitmap words one at a time (1 to 8 words) until a free slot
// is found or the word holding the last usable slot is checked; a free runs a
// second division for the slot index unless the offset lies below the start offset.
// The result shows in the same cycle as busy drops, when the next request may already be taken.
// The bitmap is cleared by reset itself.
module bitmap_slot_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_opcode,
   input  logic [bsa_pkg::OFF_W-1:0]   req_free_offset,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [bsa_pkg::OFF_W-1:0]   rsp_alloc_offset,
   output logic [bsa_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic [bsa_pkg::CNT_W-1:0]   rsp_used_count,
   output logic                        rsp_is_full,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bsa_pkg::ADDR_W-1:0]  paddr,
   input  logic [bsa_pkg::DATA_W-1:0]  pwdata,
   output logic [bsa_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   bsa_pkg::cfg_type     cfg;
   bsa_pkg::dp_cmd_type  cmd;
   bsa_pkg::dp_stat_type stat;

   bsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bsa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_free_offset  (req_free_offset),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_alloc_offset (rsp_alloc_offset),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_used_count   (rsp_used_count),
      .rsp_is_full      (rsp_is_full)
   );

endmodule

[sim/testbench.sv]
// Testbench for bitmap_slot_allocator: directed and random allocate/free requests
// checked against a cycle-free predictor of the slab bitmap, with APB register writes.
// Depends on bsa_pkg and the bitmap_slot_allocator RTL.
`timescale 1ns / 1ps

module testbench;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;
   localparam int   STALL_LIMIT = 4000;
   localparam int   MAX_REPORTS = 10;

   typedef enum logic { ITEM_REQ, ITEM_CFG } item_kind_type;

   typedef struct {
      item_kind_type                 kind;
      logic                          op;
      logic [bsa_pkg::OFF_W-1:0]     off;
      bsa_pkg::reg_index_type        reg_idx;
      logic [bsa_pkg::DATA_W-1:0]    value;
      int unsigned                   gap_pct;
   } pending_op_type;

   typedef struct {
      bsa_pkg::status_type           status;
      logic [bsa_pkg::OFF_W-1:0]     offset;
      logic [bsa_pkg::SLOT_W-1:0]    slot;
      logic [bsa_pkg::CNT_W-1:0]     used;
      logic                          full;
   } alloc_result_type;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_opcode = 1'b0;
   logic [bsa_pkg::OFF_W-1:0] req_free_offset = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [bsa_pkg::OFF_W-1:0] rsp_alloc_offset;
   logic [bsa_pkg::SLOT_W-1:0] rsp_slot_index;
   logic [bsa_pkg::CNT_W-1:0] rsp_used_count;
   logic rsp_is_full;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [bsa_pkg::ADDR_W-1:0] paddr = '0;
   logic [bsa_pkg::DATA_W-1:0] pwdata = '0;
   logic [bsa_pkg::DATA_W-1:0] prdata;
   logic pready;

   bitmap_slot_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_free_offset(req_free_offset),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_alloc_offset(rsp_alloc_offset), .rsp_slot_index(rsp_slot_index),
      .rsp_used_count(rsp_used_count), .rsp_is_full(rsp_is_full),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pending_op_type   pending_ops[$];
   alloc_result_type pending_results[$];
   int unsigned mismatch_count = 0;
   int unsigned stall_cycles = 0;
   int unsigned issued = 0;
   int unsigned results_seen = 0;

   // predictor copy of registers and slab state
   logic [bsa_pkg::OBJ_W-1:0]     cfg_obj   = bsa_pkg::OBJ_W'(bsa_pkg::RST_OBJ_SIZE);
   logic [bsa_pkg::OFF_W-1:0]     cfg_start = bsa_pkg::OFF_W'(bsa_pkg::RST_START_OFF);
   logic [bsa_pkg::CNT_W-1:0]     cfg_cnt   = bsa_pkg::CNT_W'(bsa_pkg::RST_SLOT_CNT);
   logic [bsa_pkg::MAX_SLOTS-1:0] slot_used = '0;
   int unsigned                   used_total = 0;

   // register values as the stimulus sees them
   logic [bsa_pkg::OBJ_W-1:0] gen_obj   = bsa_pkg::OBJ_W'(bsa_pkg::RST_OBJ_SIZE);
   logic [bsa_pkg::OFF_W-1:0] gen_start = bsa_pkg::OFF_W'(bsa_pkg::RST_START_OFF);
   logic [bsa_pkg::CNT_W-1:0] gen_cnt   = bsa_pkg::CNT_W'(bsa_pkg::RST_SLOT_CNT);

   function automatic int unsigned aligned_bytes(input logic [bsa_pkg::OBJ_W-1:0] obj);
      int unsigned sz;
      sz = (obj == 0) ? 1 : obj;
      return ((sz + bsa_pkg::ALIGN_STEP - 1) >> bsa_pkg::ALIGN_BITS) << bsa_pkg::ALIGN_BITS;
   endfunction

   function automatic int unsigned usable_slots(input logic [bsa_pkg::OBJ_W-1:0] obj,
                                                input logic [bsa_pkg::OFF_W-1:0] so,
                                                input logic [bsa_pkg::CNT_W-1:0] cnt);
      int unsigned fit, n;
      fit = (so >= bsa_pkg::SLAB_BYTES) ? 0 :
            (bsa_pkg::SLAB_BYTES - so) / aligned_bytes(obj);
      n = cnt;
      if (n > bsa_pkg::MAX_SLOTS) n = bsa_pkg::MAX_SLOTS;
      if (n > fit) n = fit;
      return n;
   endfunction

   function automatic alloc_result_type serve_request(
         input logic op, input logic [bsa_pkg::OFF_W-1:0] foff);
      alloc_result_type r;
      int unsigned a, n, s;
      bit found;
      a = aligned_bytes(cfg_obj);
      n = usable_slots(cfg_obj, cfg_start, cfg_cnt);
      r.status = bsa_pkg::ST_DONE;
      r.offset = '0;
      r.slot = '0;
      found = 0;
      if (op == OP_ALLOC) begin
         for (s = 0; s < n; s++) begin
            if (!slot_used[s]) begin
               found = 1;
               break;
            end
         end
         if (found) begin
            slot_used[s] = 1'b1;
            used_total++;
            r.offset = bsa_pkg::OFF_W'(cfg_start + s * a);
            r.slot = bsa_pkg::SLOT_W'(s);
         end else begin
            r.status = bsa_pkg::ST_FULL;
         end
      end else if (foff < cfg_start || foff >= bsa_pkg::SLAB_BYTES) begin
         r.status = bsa_pkg::ST_BAD;
      end else begin
         s = (foff - cfg_start) / a;
         if (s >= bsa_pkg::MAX_SLOTS) begin
            r.status = bsa_pkg::ST_BAD;
         end else begin
            if (slot_used[s]) begin
               slot_used[s] = 1'b0;
               if (used_total > 0) used_total--;
            end
            r.slot = bsa_pkg::SLOT_W'(s);
         end
      end
      r.used = bsa_pkg::CNT_W'(used_total);
      r.full = (used_total >= n);
      return r;
   endfunction

   function automatic void apply_register(input bsa_pkg::reg_index_type idx,
                                          input logic [bsa_pkg::DATA_W-1:0] value);
      case (idx)
         bsa_pkg::REG_OBJECT_SIZE: cfg_obj = value[bsa_pkg::OBJ_W-1:0];
         bsa_pkg::REG_START_OFFSET: cfg_start = value[bsa_pkg::OFF_W-1:0];
         bsa_pkg::REG_SLOT_COUNT: cfg_cnt = value[bsa_pkg::CNT_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic add_req(input logic op, input logic [bsa_pkg::OFF_W-1:0] off,
                          input int unsigned gap);
      pending_op_type p;
      p.kind = ITEM_REQ;
      p.op = op;
      p.off = off;
      p.reg_idx = bsa_pkg::REG_OBJECT_SIZE;
      p.value = '0;
      p.gap_pct = gap;
      pending_ops.push_back(p);
   endtask

   task automatic add_cfg(input bsa_pkg::reg_index_type idx, input int unsigned value,
                          input int unsigned gap);
      pending_op_type p;
      p.kind = ITEM_CFG;
      p.op = OP_ALLOC;
      p.off = '0;
      p.reg_idx = idx;
      p.value = value;
      p.gap_pct = gap;
      pending_ops.push_back(p);
      case (idx)
         bsa_pkg::REG_OBJECT_SIZE: gen_obj = value[bsa_pkg::OBJ_W-1:0];
         bsa_pkg::REG_START_OFFSET: gen_start = value[bsa_pkg::OFF_W-1:0];
         bsa_pkg::REG_SLOT_COUNT: gen_cnt = value[bsa_pkg::CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic randomize_config(input int unsigned gap);
      int unsigned pick;
      pick = $urandom_range(99);
      if ($urandom_range(3) != 0)
         add_cfg(bsa_pkg::REG_OBJECT_SIZE, (pick < 80) ? $urandom_range(64, 1) :
                 (pick < 90) ? $urandom_range(8191, 0) : $urandom_range(4096, 65), gap);
      pick = $urandom_range(99);
      if ($urandom_range(3) != 0)
         add_cfg(bsa_pkg::REG_START_OFFSET, (pick < 70) ? $urandom_range(255, 0) :
                 $urandom_range(4095, 0), gap);
      pick = $urandom_range(99);
      add_cfg(bsa_pkg::REG_SLOT_COUNT, (pick < 75) ? $urandom_range(48, 1) :
              (pick < 85) ? 0 : $urandom_range(1023, 49), gap);
   endtask

   // mostly allocates and frees inside usable slots, some random offsets
   task automatic add_segment(input int unsigned count, input int unsigned gap);
      int unsigned a, n, slot, off, pick;
      a = aligned_bytes(gen_obj);
      n = usable_slots(gen_obj, gen_start, gen_cnt);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            add_req(OP_ALLOC, bsa_pkg::OFF_W'($urandom), gap);
         end else begin
            off = $urandom_range(4095, 0);
            if (pick < 88 && n != 0) begin
               slot = $urandom_range(n - 1, 0);
               off = gen_start + slot * a + $urandom_range(a - 1, 0);
               if (off > 4095) off = gen_start + slot * a;
            end
            add_req(OP_FREE, bsa_pkg::OFF_W'(off), gap);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // request and register-write driver
   always @(posedge clock) begin
      pending_op_type head;
      logic take, nxt_start, nxt_psel, nxt_penable;
      if (reset) begin
         start <= 1'b0;
         psel <= 1'b0;
         penable <= 1'b0;
      end else begin
         take = start && !busy;
         nxt_start = start && !take;
         nxt_psel = psel;
         nxt_penable = penable;
         if (rsp_valid) results_seen++;
         if (take) begin
            pending_results.push_back(serve_request(req_opcode, req_free_offset));
            issued++;
            pending_ops.pop_front();
         end
         if (psel && penable) begin
            apply_register(bsa_pkg::reg_index_type'(paddr[3:2]), pwdata);
            pending_ops.pop_front();
            nxt_psel = 1'b0;
            nxt_penable = 1'b0;
         end else if (psel) begin
            nxt_penable = 1'b1;
         end
         if (!nxt_start && !psel && pending_ops.size() != 0) begin
            head = pending_ops[0];
            if (head.kind == ITEM_REQ) begin
               if ($urandom_range(99) >= head.gap_pct) begin
                  nxt_start = 1'b1;
                  req_opcode <= head.op;
                  req_free_offset <= head.off;
               end
            end else if (issued == results_seen && !busy) begin
               nxt_psel = 1'b1;
               nxt_penable = 1'b0;
               pwrite <= 1'b1;
               paddr <= {head.reg_idx, 2'b00};
               pwdata <= head.value;
            end
         end
         start <= nxt_start;
         psel <= nxt_psel;
         penable <= nxt_penable;
      end
   end

   // result checker
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         stall_cycles = 0;
      end else begin
         if ((start && !busy) || rsp_valid || (psel && penable))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result with no request outstanding", $realtime);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status != want.status || rsp_alloc_offset != want.offset ||
                   rsp_slot_index != want.slot || rsp_used_count != want.used ||
                   rsp_is_full != want.full) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                              $realtime,
                              want.status, want.offset, want.slot, want.used, want.full,
                              rsp_status, rsp_alloc_offset, rsp_slot_index,
                              rsp_used_count, rsp_is_full);
               end
            end
         end
      end
   end

   initial begin
      @(posedge clock);
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int unsigned gaps[3];
      gaps = '{21, 86, 0};

      // empty slab at reset values, then a three-slot slab
      add_req(OP_ALLOC, 12'hABC, 21);
      add_req(OP_FREE, 12'd0, 21);
      add_req(OP_FREE, 12'd64, 21);
      add_cfg(bsa_pkg::REG_SLOT_COUNT, 3, 21);
      repeat (4) add_req(OP_ALLOC, 12'h543, 21);
      add_req(OP_FREE, 12'd77, 21);
      add_req(OP_FREE, 12'd4095, 21);
      add_req(OP_ALLOC, 12'hFFF, 21);
      // zero size, start at the top: no slot fits, old bits stay counted
      add_cfg(bsa_pkg::REG_OBJECT_SIZE, 0, 21);
      add_cfg(bsa_pkg::REG_START_OFFSET, 4095, 21);
      add_cfg(bsa_pkg::REG_SLOT_COUNT, 512, 21);
      add_req(OP_ALLOC, 12'h000, 21);
      add_req(OP_FREE, 12'd4095, 21);
      add_req(OP_FREE, 12'd4094, 21);
      // one object fills the slab; oversized object fits nowhere
      add_cfg(bsa_pkg::REG_OBJECT_SIZE, 4096, 21);
      add_cfg(bsa_pkg::REG_START_OFFSET, 0, 21);
      add_cfg(bsa_pkg::REG_SLOT_COUNT, 1023, 21);
      add_req(OP_ALLOC, 12'h0F0, 21);
      add_req(OP_ALLOC, 12'h00F, 21);
      add_req(OP_FREE, 12'd4095, 21);
      add_cfg(bsa_pkg::REG_OBJECT_SIZE, 8191, 21);
      add_req(OP_ALLOC, 12'h111, 21);
      add_req(OP_FREE, 12'd0, 21);
      // free bits left beyond the usable count
      add_cfg(bsa_pkg::REG_OBJECT_SIZE, 1, 21);
      add_cfg(bsa_pkg::REG_SLOT_COUNT, 2, 21);
      add_req(OP_FREE, 12'd8, 21);
      add_req(OP_FREE, 12'd16, 21);

      for (int ph = 0; ph < 3; ph++) begin
         for (int seg = 0; seg < 4; seg++) begin
            randomize_config(gaps[ph]);
            add_segment(15, gaps[ph]);
         end
      end

      // fill the lower words so the scan walks several of them
      add_cfg(bsa_pkg::REG_OBJECT_SIZE, 8, 0);
      add_cfg(bsa_pkg::REG_START_OFFSET, 0, 0);
      add_cfg(bsa_pkg::REG_SLOT_COUNT, bsa_pkg::MAX_SLOTS, 0);
      repeat (200) add_req(OP_ALLOC, bsa_pkg::OFF_W'($urandom), 0);
      add_segment(10, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || pending_results.size() != 0 || busy || start)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
